// ----- src/lncu_pkg.sv -----
`timescale 1ns / 1ps

package lncu_pkg;

   // Grid geometry.
   localparam int MAX_ROWS   = 64;
   localparam int MAX_COLS   = 64;
   localparam int ROW_W      = $clog2(MAX_ROWS);
   localparam int COL_W      = $clog2(MAX_COLS);
   localparam int CELL_COUNT = MAX_ROWS * MAX_COLS;
   localparam int ADDR_W     = $clog2(CELL_COUNT);

   // Configuration registers.
   localparam int CFG_W     = 7;
   localparam int CSR_IDX_W = 8;
   localparam logic [CSR_IDX_W-1:0] REG_NUM_ROWS = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_NUM_COLS = CSR_IDX_W'(1);
   localparam logic [CFG_W-1:0]     NUM_ROWS_RST = CFG_W'(64);
   localparam logic [CFG_W-1:0]     NUM_COLS_RST = CFG_W'(64);

   // Width wide enough for both a register value and a neighbor coordinate.
   localparam int LIM_W = (CFG_W > ROW_W + 1) ?
                          ((CFG_W > COL_W + 1) ? CFG_W : COL_W + 1) :
                          ((ROW_W > COL_W) ? ROW_W + 1 : COL_W + 1);

   // Operation codes.
   localparam logic OP_BIRTH = 1'b0;
   localparam logic OP_DEATH = 1'b1;

   // Stored word: alive bit and neighbor count.
   localparam int CNT_W = 4;
   localparam logic [CNT_W-1:0] COUNT_MAX = CNT_W'(8);

   typedef struct packed {
      logic             alive;
      logic [CNT_W-1:0] count;
   } word_type;

   localparam int WORD_W = CNT_W + 1;

   // Walk order: eight neighbors, then the cell itself, then the last write.
   localparam int STEP_W = 4;
   localparam logic [STEP_W-1:0] SELF_STEP = STEP_W'(8);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(9);

   // Offset codes for one axis.
   localparam logic [1:0] OFF_MINUS = 2'd0;
   localparam logic [1:0] OFF_ZERO  = 2'd1;
   localparam logic [1:0] OFF_PLUS  = 2'd2;

   typedef struct packed {
      logic [1:0] dr;
      logic [1:0] dc;
   } offset_type;

   // Neighbor lookup for one step.
   typedef struct packed {
      logic [ADDR_W-1:0] addr;
      logic              in_grid;
      logic              is_self;
      logic              cell_ok;
   } nbr_type;

   function automatic offset_type step_offset(input logic [STEP_W-1:0] step);
      offset_type off;
      unique case (step)
         4'd0:    off = '{dr: OFF_MINUS, dc: OFF_MINUS};
         4'd1:    off = '{dr: OFF_MINUS, dc: OFF_ZERO};
         4'd2:    off = '{dr: OFF_MINUS, dc: OFF_PLUS};
         4'd3:    off = '{dr: OFF_ZERO,  dc: OFF_MINUS};
         4'd4:    off = '{dr: OFF_ZERO,  dc: OFF_PLUS};
         4'd5:    off = '{dr: OFF_PLUS,  dc: OFF_MINUS};
         4'd6:    off = '{dr: OFF_PLUS,  dc: OFF_ZERO};
         4'd7:    off = '{dr: OFF_PLUS,  dc: OFF_PLUS};
         default: off = '{dr: OFF_ZERO,  dc: OFF_ZERO};
      endcase
      return off;
   endfunction

endpackage

// ----- src/lncu_req_if.sv -----
`timescale 1ns / 1ps

interface lncu_req_if;
   logic                       valid;
   logic                       ready;
   logic                       op;
   logic [lncu_pkg::ROW_W-1:0] row;
   logic [lncu_pkg::COL_W-1:0] col;

   modport source (output valid, output op, output row, output col, input ready);
   modport sink   (input valid, input op, input row, input col, output ready);
endinterface

// ----- src/lncu_rsp_if.sv -----
`timescale 1ns / 1ps

interface lncu_rsp_if;
   logic valid;
   logic ready;
   logic alive_now;
   logic count_fault;

   modport source (output valid, output alive_now, output count_fault, input ready);
   modport sink   (input valid, input alive_now, input count_fault, output ready);
endinterface

// ----- src/lncu_csr_if.sv -----
`timescale 1ns / 1ps

interface lncu_csr_if;
   logic                           valid;
   logic                           ready;
   logic [lncu_pkg::CSR_IDX_W-1:0] index;
   logic [lncu_pkg::CFG_W-1:0]     data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- src/life_neighbor_count_update.sv -----
`timescale 1ns / 1ps
// A cell inside the grid is walked in steps: the accept cycle issues the first read, then nine
// steps stream reads and writes through the single read and single write port of the cell
// memory (eight neighbors, then the cell). The result word is registered after the last step,
// later if the response port stalls. A cell outside the grid in use returns a zero word through
// the done state. After reset a clearing pass zeroes the memory; req_bus.ready stays low meanwhile,
// while configuration writes are taken. Registers reset to 64 rows and 64 columns.

module life_neighbor_count_update (
   input  logic       clock,
   input  logic       reset,
   lncu_req_if.sink   req_bus,
   lncu_rsp_if.source rsp_bus,
   lncu_csr_if.sink   csr_bus
);

   typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_RUN, ST_DONE} state_type;

   state_type                      state_ff, state_in;
   logic [lncu_pkg::ADDR_W-1:0]    clr_ff, clr_in;
   logic [lncu_pkg::STEP_W-1:0]    step_ff, step_in;
   logic                           fault_ff, fault_in;
   logic                           res_alive_ff, res_alive_in;
   logic                           res_fault_ff, res_fault_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           rsp_alive_ff, rsp_alive_in;
   logic                           rsp_fault_ff, rsp_fault_in;
   logic [lncu_pkg::CFG_W-1:0]     num_rows_ff, num_rows_in;
   logic [lncu_pkg::CFG_W-1:0]     num_cols_ff, num_cols_in;
   logic                           pend_we_ff, pend_we_in;
   logic                           pend_self_ff, pend_self_in;
   logic [lncu_pkg::ADDR_W-1:0]    pend_addr_ff, pend_addr_in;
   logic                           op_ff, op_in;
   logic [lncu_pkg::ROW_W-1:0]     row_ff, row_in;
   logic [lncu_pkg::COL_W-1:0]     col_ff, col_in;

   logic                           accept;
   logic                           out_free;
   logic                           cur_op;
   logic [lncu_pkg::ROW_W-1:0]     cur_row;
   logic [lncu_pkg::COL_W-1:0]     cur_col;
   logic [lncu_pkg::STEP_W-1:0]    cur_step;
   lncu_pkg::nbr_type              nbr;
   logic                           rd_en;
   logic [lncu_pkg::WORD_W-1:0]    rd_data;
   logic                           wr_en;
   logic [lncu_pkg::ADDR_W-1:0]    wr_addr;
   logic [lncu_pkg::WORD_W-1:0]    wr_data;
   lncu_pkg::word_type             upd_word;
   logic                           upd_fault;
   logic                           step_fault;

   assign req_bus.ready       = (state_ff == ST_IDLE);
   assign csr_bus.ready       = 1'b1;
   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.alive_now   = rsp_alive_ff;
   assign rsp_bus.count_fault = rsp_fault_ff;

   assign accept   = req_bus.valid && (state_ff == ST_IDLE);
   assign out_free = !rsp_valid_ff || rsp_bus.ready;

   // While idle the incoming word drives the lookup so step 0 is read in the accept cycle.
   assign cur_op   = (state_ff == ST_IDLE) ? req_bus.op  : op_ff;
   assign cur_row  = (state_ff == ST_IDLE) ? req_bus.row : row_ff;
   assign cur_col  = (state_ff == ST_IDLE) ? req_bus.col : col_ff;
   assign cur_step = (state_ff == ST_IDLE) ? '0 : step_ff;

   lncu_nbr_addr u_nbr_addr (
      .row      (cur_row),
      .col      (cur_col),
      .step     (cur_step),
      .num_rows (num_rows_ff),
      .num_cols (num_cols_ff),
      .nbr      (nbr)
   );

   lncu_count_upd u_count_upd (
      .rd_word (lncu_pkg::word_type'(rd_data)),
      .grow    (op_ff == lncu_pkg::OP_BIRTH),
      .is_self (pend_self_ff),
      .wr_word (upd_word),
      .fault   (upd_fault)
   );

   lncu_ram #(
      .WIDTH (lncu_pkg::WORD_W),
      .DEPTH (lncu_pkg::CELL_COUNT)
   ) u_cell_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (nbr.addr),
      .rd_data (rd_data)
   );

   assign rd_en = (accept && nbr.cell_ok) ||
                  ((state_ff == ST_RUN) && (step_ff < lncu_pkg::LAST_STEP));

   assign wr_en   = (state_ff == ST_CLEAR) || ((state_ff == ST_RUN) && pend_we_ff);
   assign wr_addr = (state_ff == ST_CLEAR) ? clr_ff : pend_addr_ff;
   assign wr_data = (state_ff == ST_CLEAR) ? '0 : lncu_pkg::WORD_W'(upd_word);

   assign step_fault = pend_we_ff && upd_fault;

   // The pending entry is the one whose read data arrives next cycle.
   assign pend_we_in   = rd_en && nbr.in_grid;
   assign pend_self_in = nbr.is_self;
   assign pend_addr_in = nbr.addr;

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      step_in      = step_ff;
      fault_in     = fault_ff;
      res_alive_in = res_alive_ff;
      res_fault_in = res_fault_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_alive_in = rsp_alive_ff;
      rsp_fault_in = rsp_fault_ff;
      num_rows_in  = num_rows_ff;
      num_cols_in  = num_cols_ff;
      op_in        = op_ff;
      row_in       = row_ff;
      col_in       = col_ff;

      if (csr_bus.valid) begin
         if (csr_bus.index == lncu_pkg::REG_NUM_ROWS) begin
            num_rows_in = csr_bus.data;
         end else if (csr_bus.index == lncu_pkg::REG_NUM_COLS) begin
            num_cols_in = csr_bus.data;
         end
      end

      unique case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + lncu_pkg::ADDR_W'(1);
            if (clr_ff == lncu_pkg::ADDR_W'(lncu_pkg::CELL_COUNT - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               op_in  = cur_op;
               row_in = cur_row;
               col_in = cur_col;
               if (nbr.cell_ok) begin
                  state_in = ST_RUN;
                  step_in  = lncu_pkg::STEP_W'(1);
                  fault_in = 1'b0;
               end else begin
                  // Cell outside the grid in use: nothing changes, both fields are zero.
                  state_in     = ST_DONE;
                  res_alive_in = 1'b0;
                  res_fault_in = 1'b0;
               end
            end
         end
         ST_RUN: begin
            step_in  = step_ff + lncu_pkg::STEP_W'(1);
            fault_in = fault_ff || step_fault;
            if (step_ff == lncu_pkg::LAST_STEP) begin
               res_alive_in = (op_ff == lncu_pkg::OP_BIRTH);
               res_fault_in = fault_ff || step_fault;
               if (out_free) begin
                  state_in     = ST_IDLE;
                  rsp_valid_in = 1'b1;
                  rsp_alive_in = (op_ff == lncu_pkg::OP_BIRTH);
                  rsp_fault_in = fault_ff || step_fault;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_alive_in = res_alive_ff;
               rsp_fault_in = res_fault_ff;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         step_ff      <= '0;
         fault_ff     <= 1'b0;
         res_alive_ff <= 1'b0;
         res_fault_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rsp_alive_ff <= 1'b0;
         rsp_fault_ff <= 1'b0;
         num_rows_ff  <= lncu_pkg::NUM_ROWS_RST;
         num_cols_ff  <= lncu_pkg::NUM_COLS_RST;
         pend_we_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         step_ff      <= step_in;
         fault_ff     <= fault_in;
         res_alive_ff <= res_alive_in;
         res_fault_ff <= res_fault_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_alive_ff <= rsp_alive_in;
         rsp_fault_ff <= rsp_fault_in;
         num_rows_ff  <= num_rows_in;
         num_cols_ff  <= num_cols_in;
         pend_we_ff   <= pend_we_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      row_ff       <= row_in;
      col_ff       <= col_in;
      pend_self_ff <= pend_self_in;
      pend_addr_ff <= pend_addr_in;
   end

endmodule

// ----- src/lncu_ram.sv -----
`timescale 1ns / 1ps

module lncu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ----- src/lncu_nbr_addr.sv -----
`timescale 1ns / 1ps

module lncu_nbr_addr (
   input  logic [lncu_pkg::ROW_W-1:0]  row,
   input  logic [lncu_pkg::COL_W-1:0]  col,
   input  logic [lncu_pkg::STEP_W-1:0] step,
   input  logic [lncu_pkg::CFG_W-1:0]  num_rows,
   input  logic [lncu_pkg::CFG_W-1:0]  num_cols,
   output lncu_pkg::nbr_type           nbr
);

   lncu_pkg::offset_type             off;
   logic [lncu_pkg::LIM_W-1:0]       rows_use;
   logic [lncu_pkg::LIM_W-1:0]       cols_use;
   logic [lncu_pkg::ROW_W:0]         nr;
   logic [lncu_pkg::COL_W:0]         nc;
   logic                             row_under;
   logic                             col_under;
   logic                             row_ok;
   logic                             col_ok;

   assign off = lncu_pkg::step_offset(step);

   // Register values above the grid act as the full grid.
   assign rows_use = (lncu_pkg::LIM_W'(num_rows) > lncu_pkg::LIM_W'(lncu_pkg::MAX_ROWS)) ?
                     lncu_pkg::LIM_W'(lncu_pkg::MAX_ROWS) : lncu_pkg::LIM_W'(num_rows);
   assign cols_use = (lncu_pkg::LIM_W'(num_cols) > lncu_pkg::LIM_W'(lncu_pkg::MAX_COLS)) ?
                     lncu_pkg::LIM_W'(lncu_pkg::MAX_COLS) : lncu_pkg::LIM_W'(num_cols);

   always_comb begin
      row_under = 1'b0;
      col_under = 1'b0;
      unique case (off.dr)
         lncu_pkg::OFF_MINUS: begin
            nr        = {1'b0, row} - (lncu_pkg::ROW_W+1)'(1);
            row_under = (row == '0);
         end
         lncu_pkg::OFF_PLUS: nr = {1'b0, row} + (lncu_pkg::ROW_W+1)'(1);
         default:            nr = {1'b0, row};
      endcase
      unique case (off.dc)
         lncu_pkg::OFF_MINUS: begin
            nc        = {1'b0, col} - (lncu_pkg::COL_W+1)'(1);
            col_under = (col == '0);
         end
         lncu_pkg::OFF_PLUS: nc = {1'b0, col} + (lncu_pkg::COL_W+1)'(1);
         default:            nc = {1'b0, col};
      endcase
   end

   assign row_ok = !row_under && (lncu_pkg::LIM_W'(nr) < rows_use);
   assign col_ok = !col_under && (lncu_pkg::LIM_W'(nc) < cols_use);

   assign nbr.addr = lncu_pkg::ADDR_W'(nr[lncu_pkg::ROW_W-1:0]) *
                     lncu_pkg::ADDR_W'(lncu_pkg::MAX_COLS) +
                     lncu_pkg::ADDR_W'(nc[lncu_pkg::COL_W-1:0]);
   assign nbr.is_self = (step == lncu_pkg::SELF_STEP);
   assign nbr.in_grid = row_ok && col_ok && (step <= lncu_pkg::SELF_STEP);
   assign nbr.cell_ok = (lncu_pkg::LIM_W'(row) < rows_use) &&
                        (lncu_pkg::LIM_W'(col) < cols_use);

endmodule

// ----- src/lncu_count_upd.sv -----
`timescale 1ns / 1ps

module lncu_count_upd (
   input  lncu_pkg::word_type rd_word,
   input  logic               grow,
   input  logic               is_self,
   output lncu_pkg::word_type wr_word,
   output logic               fault
);

   always_comb begin
      wr_word = rd_word;
      fault   = 1'b0;
      priority if (is_self) begin
         // The cell's own count stays; only its alive bit changes.
         wr_word.alive = grow;
      end else if (grow) begin
         if (rd_word.count >= lncu_pkg::COUNT_MAX) begin
            fault = 1'b1;
         end else begin
            wr_word.count = rd_word.count + lncu_pkg::CNT_W'(1);
         end
      end else begin
         if (rd_word.count == '0) begin
            fault = 1'b1;
         end else begin
            wr_word.count = rd_word.count - lncu_pkg::CNT_W'(1);
         end
      end
   end

endmodule

// ----- test/life_neighbor_count_update_tb.sv -----
`timescale 1ns / 1ps

module life_neighbor_count_update_tb;

   typedef struct {
      logic                       op;
      logic [lncu_pkg::ROW_W-1:0] row;
      logic [lncu_pkg::COL_W-1:0] col;
   } cell_change_type;

   typedef struct {
      logic alive_now;
      logic count_fault;
   } cell_outcome_type;

   typedef enum int {FLOW_FREE, FLOW_COIN, FLOW_SPARSE, FLOW_BURSTY} flow_mode_type;

   logic clock;
   logic reset;

   lncu_req_if req_if();
   lncu_rsp_if rsp_if();
   lncu_csr_if csr_if();

   life_neighbor_count_update uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if),
      .csr_bus (csr_if)
   );

   // Shadow copy of the grid and its two registers.
   bit                       alive_map  [lncu_pkg::CELL_COUNT];
   bit [lncu_pkg::CNT_W-1:0] live_count [lncu_pkg::CELL_COUNT];
   bit [lncu_pkg::CFG_W-1:0] rows_reg = lncu_pkg::NUM_ROWS_RST;
   bit [lncu_pkg::CFG_W-1:0] cols_reg = lncu_pkg::NUM_COLS_RST;

   cell_change_type  pending_q[$];
   cell_outcome_type outcome_q[$];

   int mismatch_count  = 0;
   int words_taken     = 0;
   int results_seen    = 0;
   int fault_results   = 0;
   int outside_results = 0;
   int csr_writes      = 0;
   int settings_used   = 1;

   logic          req_taken  = 1'b0;
   int            burst_left = 0;
   int            gap_left   = 0;
   bit            drain_hold = 1'b0;
   flow_mode_type flow_mode  = FLOW_FREE;
   int            flow_left  = 0;

   function automatic int span_in_use(bit [lncu_pkg::CFG_W-1:0] value, int limit);
      return (value > limit) ? limit : int'(value);
   endfunction

   function automatic cell_outcome_type apply_change(cell_change_type chg);
      cell_outcome_type res;
      int rows, cols, nr, nc, idx, dr, dc;
      rows = span_in_use(rows_reg, lncu_pkg::MAX_ROWS);
      cols = span_in_use(cols_reg, lncu_pkg::MAX_COLS);
      res.alive_now   = 1'b0;
      res.count_fault = 1'b0;
      if (int'(chg.row) >= rows || int'(chg.col) >= cols) begin
         outside_results++;
         return res;
      end
      alive_map[int'(chg.row) * lncu_pkg::MAX_COLS + int'(chg.col)] =
         (chg.op == lncu_pkg::OP_BIRTH);
      for (dr = -1; dr <= 1; dr++) begin
         for (dc = -1; dc <= 1; dc++) begin
            nr = int'(chg.row) + dr;
            nc = int'(chg.col) + dc;
            if ((dr != 0 || dc != 0) && nr >= 0 && nc >= 0 && nr < rows && nc < cols) begin
               idx = nr * lncu_pkg::MAX_COLS + nc;
               // A count that would leave 0..8 stays put and flags the word.
               if (chg.op == lncu_pkg::OP_BIRTH) begin
                  if (live_count[idx] >= lncu_pkg::COUNT_MAX) res.count_fault = 1'b1;
                  else live_count[idx]++;
               end else begin
                  if (live_count[idx] == 0) res.count_fault = 1'b1;
                  else live_count[idx]--;
               end
            end
         end
      end
      res.alive_now = alive_map[int'(chg.row) * lncu_pkg::MAX_COLS + int'(chg.col)];
      if (res.count_fault) fault_results++;
      return res;
   endfunction

   task automatic report_mismatch(string what, logic got, logic want);
      mismatch_count++;
      $display("%0t: result %0d: %s: got %b, expected %b", $time, results_seen, what, got,
               want);
   endtask

   task automatic queue_cell(logic op, int row, int col);
      cell_change_type chg;
      chg.op  = op;
      chg.row = lncu_pkg::ROW_W'(row);
      chg.col = lncu_pkg::COL_W'(col);
      pending_q.push_back(chg);
   endtask

   task automatic wait_idle();
      forever begin
         @(negedge clock);
         if (pending_q.size() == 0 && outcome_q.size() == 0) break;
      end
      // Then let the block settle before the next step of the test.
      repeat (16) @(negedge clock);
   endtask

   task automatic write_csr(logic [lncu_pkg::CSR_IDX_W-1:0] idx,
                            logic [lncu_pkg::CFG_W-1:0] value);
      @(negedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= value;
      forever begin
         @(posedge clock);
         if (csr_if.ready) break;
      end
      if (idx == lncu_pkg::REG_NUM_ROWS) rows_reg = value;
      else cols_reg = value;
      csr_writes++;
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   task automatic run_phase(logic [lncu_pkg::CFG_W-1:0] rows, logic [lncu_pkg::CFG_W-1:0] cols,
                            int count, int birth_pct);
      int span_r, span_c, win_r, win_c, org_r, org_c, r, c, i;
      logic op;
      wait_idle();
      write_csr(lncu_pkg::REG_NUM_ROWS, rows);
      write_csr(lncu_pkg::REG_NUM_COLS, cols);
      settings_used++;
      span_r = span_in_use(rows_reg, lncu_pkg::MAX_ROWS);
      span_c = span_in_use(cols_reg, lncu_pkg::MAX_COLS);
      win_r  = (span_r < 6) ? span_r : 6;
      win_c  = (span_c < 6) ? span_c : 6;
      org_r  = 0;
      org_c  = 0;
      @(posedge clock);
      for (i = 0; i < count; i++) begin
         // Most words land in a small moving window so that neighbors interact.
         if (i % 40 == 0) begin
            org_r = (span_r > win_r) ? $urandom_range(0, span_r - win_r) : 0;
            org_c = (span_c > win_c) ? $urandom_range(0, span_c - win_c) : 0;
         end
         op = ($urandom_range(0, 99) < birth_pct) ? lncu_pkg::OP_BIRTH : lncu_pkg::OP_DEATH;
         if (span_r == 0 || span_c == 0 || $urandom_range(0, 9) == 0) begin
            r = $urandom_range(0, lncu_pkg::MAX_ROWS - 1);
            c = $urandom_range(0, lncu_pkg::MAX_COLS - 1);
         end else if ($urandom_range(0, 3) == 0) begin
            r = $urandom_range(0, span_r - 1);
            c = $urandom_range(0, span_c - 1);
         end else begin
            r = org_r + $urandom_range(0, win_r - 1);
            c = org_c + $urandom_range(0, win_c - 1);
         end
         queue_cell(op, r, c);
      end
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Sender: bursts of words separated by gaps, now and then held until the block drains.
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (req_if.valid && !req_taken) begin
         // The word on the bus is still waiting for the block.
      end else if (gap_left > 0) begin
         gap_left     <= gap_left - 1;
         req_if.valid <= 1'b0;
      end else if (pending_q.size() == 0 || (drain_hold && outcome_q.size() != 0)) begin
         req_if.valid <= 1'b0;
      end else begin
         req_if.valid <= 1'b1;
         req_if.op    <= pending_q[0].op;
         req_if.row   <= pending_q[0].row;
         req_if.col   <= pending_q[0].col;
         drain_hold   <= 1'b0;
         if (burst_left > 1) begin
            burst_left <= burst_left - 1;
         end else begin
            burst_left <= $urandom_range(1, 24);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 14);
            drain_hold <= ($urandom_range(0, 15) == 0);
         end
      end
   end

   // Receiver: switches between stall patterns every so often.
   always @(negedge clock) begin
      if (flow_left == 0) begin
         flow_mode <= flow_mode_type'($urandom_range(0, 3));
         flow_left <= $urandom_range(20, 200);
      end else begin
         flow_left <= flow_left - 1;
      end
      case (flow_mode)
         FLOW_FREE:   rsp_if.ready <= 1'b1;
         FLOW_COIN:   rsp_if.ready <= 1'($urandom_range(0, 1));
         FLOW_SPARSE: rsp_if.ready <= ($urandom_range(0, 7) == 0);
         FLOW_BURSTY: rsp_if.ready <= flow_left[3];
         default:     rsp_if.ready <= 1'b1;
      endcase
   end

   always @(posedge clock) begin
      cell_change_type  seen;
      cell_outcome_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_if.valid && req_if.ready;
         if (req_if.valid && req_if.ready) begin
            seen.op  = req_if.op;
            seen.row = req_if.row;
            seen.col = req_if.col;
            outcome_q.push_back(apply_change(seen));
            void'(pending_q.pop_front());
            words_taken++;
         end
         if (rsp_if.valid && rsp_if.ready) begin
            results_seen++;
            if (outcome_q.size() == 0) begin
               report_mismatch("result with no word outstanding", rsp_if.alive_now, 1'bx);
            end else begin
               want = outcome_q.pop_front();
               if (rsp_if.alive_now !== want.alive_now)
                  report_mismatch("alive_now", rsp_if.alive_now, want.alive_now);
               if (rsp_if.count_fault !== want.count_fault)
                  report_mismatch("count_fault", rsp_if.count_fault, want.count_fault);
            end
         end
      end
   end

   initial begin
      int k;
      reset         = 1'b1;
      req_if.valid  = 1'b0;
      req_if.op     = lncu_pkg::OP_BIRTH;
      req_if.row    = '0;
      req_if.col    = '0;
      rsp_if.ready  = 1'b0;
      csr_if.valid  = 1'b0;
      csr_if.index  = lncu_pkg::REG_NUM_ROWS;
      csr_if.data   = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Corners and edges of the full grid, a death of a dead cell, and one cell born
      // nine times so that its neighbors reach the top count and then fault.
      queue_cell(lncu_pkg::OP_BIRTH, 0, 0);
      queue_cell(lncu_pkg::OP_BIRTH, 0, lncu_pkg::MAX_COLS - 1);
      queue_cell(lncu_pkg::OP_BIRTH, lncu_pkg::MAX_ROWS - 1, 0);
      queue_cell(lncu_pkg::OP_BIRTH, lncu_pkg::MAX_ROWS - 1, lncu_pkg::MAX_COLS - 1);
      queue_cell(lncu_pkg::OP_BIRTH, 5, 5);
      queue_cell(lncu_pkg::OP_DEATH, 10, 10);
      for (k = 0; k < 9; k++) queue_cell(lncu_pkg::OP_BIRTH, 20, 20);
      queue_cell(lncu_pkg::OP_DEATH, 20, 20);
      queue_cell(lncu_pkg::OP_DEATH, lncu_pkg::MAX_ROWS - 1, lncu_pkg::MAX_COLS - 1);
      queue_cell(lncu_pkg::OP_DEATH, 5, 5);
      queue_cell(lncu_pkg::OP_BIRTH, 0, 1);

      run_phase(3, 3, 120, 75);
      run_phase(3, 3, 80, 25);
      run_phase(1, 1, 40, 50);
      run_phase(0, 5, 10, 50);
      run_phase(7, 0, 6, 50);
      run_phase(127, 3, 120, 60);
      run_phase(2, 100, 100, 60);
      run_phase(8, 8, 120, 70);
      run_phase(64, 64, 150, 50);
      run_phase(65, 127, 120, 40);
      run_phase($urandom_range(1, 64), $urandom_range(1, 64), 100, 55);
      run_phase($urandom_range(1, 64), $urandom_range(1, 64), 100, 45);
      run_phase(1, 64, 60, 60);
      run_phase(64, 1, 60, 40);
      wait_idle();

      $display("Checked %0d results for %0d words over %0d grid settings (%0d register writes).",
               results_seen, words_taken, settings_used, csr_writes);
      $display("%0d results flagged a count fault; %0d named a cell outside the grid in use.",
               fault_results, outside_results);
      if (mismatch_count == 0) begin
         $display("life_neighbor_count_update: match");
      end else begin
         $display("life_neighbor_count_update: mismatch");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("life_neighbor_count_update: mismatch");
      $finish;
   end

endmodule
